/* src/kssd_pkg.sv */
// ----------------------------------------------------------------------------
// kssd_pkg
// Shared widths, reset values and stage types for the keyword score
// smoothing detector.
// ----------------------------------------------------------------------------
package kssd_pkg;

	localparam int NUM_CLASSES_DEF  = 12;
	localparam int WINDOW_DEPTH_DEF = 3;
	localparam int MISS_FACTOR_DEF  = 2;

	localparam int SCORE_W = 8;   // class score
	localparam int RUN_W   = 9;   // running score and threshold
	localparam int CLS_W   = 6;   // class index
	localparam int SLOT_W  = 3;   // window slot, up to eight slots
	localparam int SUM_W   = 11;  // window sum over up to eight slots
	localparam int TOT_W   = 12;  // running score plus window sum
	localparam int MISS_W  = 8;

	// reciprocal multiply for division by the window depth
	localparam int DIV_SHIFT = 15;
	localparam int DIV_MUL_W = 16;

	localparam logic signed [RUN_W-1:0] THRESHOLD_RESET = 9'sd90;
	localparam logic signed [RUN_W-1:0] RUN_MAX         = 9'sh0FF;
	localparam logic signed [RUN_W-1:0] RUN_MIN         = 9'sh100;
	localparam logic [MISS_W-1:0]       MISS_MAX        = 8'hFF;

	typedef struct packed {
		logic [CLS_W-1:0]          cls;
		logic [SLOT_W-1:0]         slot;
		logic signed [SCORE_W-1:0] score;
		logic                      last;
	} item_t;

	typedef struct packed {
		logic load;   // item taken into stage 1
		logic fire;   // stage 1 item moves to the result register
	} pipe_ctl_t;

	typedef struct packed {
		logic             wake_new;
		logic [CLS_W-1:0] cls;
	} wake_res_t;

endpackage

/* src/kssd_if.sv */
// ----------------------------------------------------------------------------
// kssd_if
// Valid/ready channels of the detector: scores in, results out, and the
// threshold write port.
// ----------------------------------------------------------------------------
interface kssd_score_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [kssd_pkg::SCORE_W-1:0]   class_score;

	modport source (output valid, output class_score, input ready);
	modport sink   (input valid, input class_score, output ready);
endinterface

interface kssd_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [kssd_pkg::RUN_W-1:0]     smoothed_value;
	logic                                  wake_event;
	logic [kssd_pkg::CLS_W-1:0]            wake_class;
	logic                                  frame_last;

	modport source (output valid, output smoothed_value, output wake_event,
		output wake_class, output frame_last, input ready);
	modport sink   (input valid, input smoothed_value, input wake_event,
		input wake_class, input frame_last, output ready);
endinterface

interface kssd_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [kssd_pkg::RUN_W-1:0]     wake_threshold;

	modport source (output valid, output wake_threshold, input ready);
	modport sink   (input valid, input wake_threshold, output ready);
endinterface

/* src/kssd_window.sv */
// ----------------------------------------------------------------------------
// kssd_window
// Score window: one memory per slot, read for the incoming class, written
// when the item leaves stage 1; gives the window sum of the stage 1 class.
// ----------------------------------------------------------------------------
module kssd_window #(
	parameter int NUM_CLASSES  = kssd_pkg::NUM_CLASSES_DEF,
	parameter int WINDOW_DEPTH = kssd_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  kssd_pkg::pipe_ctl_t                ctl,
	input  kssd_pkg::item_t                    item_in,
	input  kssd_pkg::item_t                    item_s1,
	output logic signed [kssd_pkg::SUM_W-1:0]  window_sum
);

	localparam int CIDX_W = $clog2(NUM_CLASSES);

	// a slot counts as written once a full frame has gone into it
	logic [WINDOW_DEPTH-1:0]               lane_valid_q;
	logic signed [kssd_pkg::SCORE_W-1:0]   lane_val [WINDOW_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_valid_q <= '0;
		end else if (ctl.load && item_in.last) begin
			for (int d = 0; d < WINDOW_DEPTH; d++) begin
				if (item_in.slot == kssd_pkg::SLOT_W'(d))
					lane_valid_q[d] <= 1'b1;
			end
		end
	end

	for (genvar d = 0; d < WINDOW_DEPTH; d++) begin : g_lane
		logic signed [kssd_pkg::SCORE_W-1:0] mem [NUM_CLASSES];
		logic signed [kssd_pkg::SCORE_W-1:0] rd_s1;
		logic                                vld_s1;

		always_ff @(posedge clk) begin
			if (ctl.load) begin
				rd_s1  <= mem[item_in.cls[CIDX_W-1:0]];
				vld_s1 <= lane_valid_q[d];
			end
			if (ctl.fire && item_s1.slot == kssd_pkg::SLOT_W'(d))
				mem[item_s1.cls[CIDX_W-1:0]] <= item_s1.score;
		end

		// current slot takes the new score directly
		assign lane_val[d] = (item_s1.slot == kssd_pkg::SLOT_W'(d)) ? item_s1.score :
			(vld_s1 ? rd_s1 : '0);
	end

	always_comb begin
		window_sum = '0;
		for (int d = 0; d < WINDOW_DEPTH; d++)
			window_sum = window_sum + kssd_pkg::SUM_W'(lane_val[d]);
	end

endmodule

/* src/kssd_smooth.sv */
// ----------------------------------------------------------------------------
// kssd_smooth
// Running score store and update: (old + window sum) / depth, truncated
// toward zero, saturated to the 9-bit range.
// ----------------------------------------------------------------------------
module kssd_smooth #(
	parameter int NUM_CLASSES  = kssd_pkg::NUM_CLASSES_DEF,
	parameter int WINDOW_DEPTH = kssd_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  kssd_pkg::pipe_ctl_t                ctl,
	input  kssd_pkg::item_t                    item_in,
	input  kssd_pkg::item_t                    item_s1,
	input  logic signed [kssd_pkg::SUM_W-1:0]  window_sum,
	output logic signed [kssd_pkg::RUN_W-1:0]  smoothed
);

	localparam int CIDX_W  = $clog2(NUM_CLASSES);
	localparam int DIV_MUL = (2 ** kssd_pkg::DIV_SHIFT + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
	localparam logic [kssd_pkg::DIV_MUL_W-1:0] DIV_MUL_V = kssd_pkg::DIV_MUL_W'(DIV_MUL);
	localparam int PROD_W  = kssd_pkg::TOT_W - 1 + kssd_pkg::DIV_MUL_W;

	logic signed [kssd_pkg::RUN_W-1:0]  run_mem [NUM_CLASSES];
	logic [NUM_CLASSES-1:0]             run_valid_q;
	logic signed [kssd_pkg::RUN_W-1:0]  run_rd_s1;
	logic                               run_vld_s1;

	logic signed [kssd_pkg::RUN_W-1:0]  old_run;
	logic signed [kssd_pkg::TOT_W-1:0]  total;
	logic                               neg;
	logic [kssd_pkg::TOT_W-1:0]         mag;
	logic [PROD_W-1:0]                  prod;
	logic [kssd_pkg::TOT_W-1:0]         quo;
	logic signed [kssd_pkg::TOT_W-1:0]  quo_s;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			run_rd_s1  <= run_mem[item_in.cls[CIDX_W-1:0]];
			run_vld_s1 <= run_valid_q[item_in.cls[CIDX_W-1:0]];
		end
		if (ctl.fire)
			run_mem[item_s1.cls[CIDX_W-1:0]] <= smoothed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= '0;
		end else if (ctl.fire) begin
			run_valid_q[item_s1.cls[CIDX_W-1:0]] <= 1'b1;
		end
	end

	assign old_run = run_vld_s1 ? run_rd_s1 : '0;
	assign total   = kssd_pkg::TOT_W'(old_run) + kssd_pkg::TOT_W'(window_sum);
	assign neg     = total[kssd_pkg::TOT_W-1];
	assign mag     = neg ? kssd_pkg::TOT_W'(-total) : kssd_pkg::TOT_W'(total);

	// magnitude stays below 2^11, so the rounded-up reciprocal is exact
	assign prod  = mag[kssd_pkg::TOT_W-2:0] * DIV_MUL_V;
	assign quo   = prod[kssd_pkg::DIV_SHIFT +: kssd_pkg::TOT_W];
	assign quo_s = neg ? -$signed(quo) : $signed(quo);

	always_comb begin
		priority if (quo_s > kssd_pkg::TOT_W'(kssd_pkg::RUN_MAX))
			smoothed = kssd_pkg::RUN_MAX;
		else if (quo_s < kssd_pkg::TOT_W'(kssd_pkg::RUN_MIN))
			smoothed = kssd_pkg::RUN_MIN;
		else
			smoothed = quo_s[kssd_pkg::RUN_W-1:0];
	end

endmodule

/* src/kssd_wake.sv */
// ----------------------------------------------------------------------------
// kssd_wake
// Hit and miss tracking: shared saturating miss counter and the wake latch.
// ----------------------------------------------------------------------------
module kssd_wake #(
	parameter int NUM_CLASSES = kssd_pkg::NUM_CLASSES_DEF,
	parameter int MISS_FACTOR = kssd_pkg::MISS_FACTOR_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  kssd_pkg::pipe_ctl_t                ctl,
	input  kssd_pkg::item_t                    item_s1,
	input  logic signed [kssd_pkg::RUN_W-1:0]  smoothed,
	input  logic signed [kssd_pkg::RUN_W-1:0]  threshold,
	output kssd_pkg::wake_res_t                wake
);

	localparam logic [kssd_pkg::MISS_W-1:0] MISS_LIMIT =
		kssd_pkg::MISS_W'(MISS_FACTOR * NUM_CLASSES);

	logic [kssd_pkg::MISS_W-1:0] miss_q;
	logic                        latched_q;
	logic                        scored;
	logic                        hit;
	logic                        miss;
	logic [kssd_pkg::MISS_W-1:0] miss_inc;

	// class zero is reported but never scored
	assign scored   = item_s1.cls != '0;
	assign hit      = scored && (smoothed > threshold);
	assign miss     = scored && !hit;
	assign miss_inc = (miss_q == kssd_pkg::MISS_MAX) ? miss_q : miss_q + 1'b1;

	assign wake.wake_new = hit && !latched_q;
	assign wake.cls      = (hit && !latched_q) ? item_s1.cls : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q    <= '0;
			latched_q <= 1'b0;
		end else if (ctl.fire) begin
			if (hit) begin
				miss_q    <= '0;
				latched_q <= 1'b1;
			end else if (miss) begin
				miss_q <= miss_inc;
				if (miss_inc > MISS_LIMIT)
					latched_q <= 1'b0;
			end
		end
	end

endmodule

/* src/keyword_score_smoothing_detector.sv */
// ----------------------------------------------------------------------------
// keyword_score_smoothing_detector
// Smooths per-class scores over a window of frames and raises a wake event
// when a class other than zero crosses the threshold while no wake is latched.
// ----------------------------------------------------------------------------
// A taken item is held in stage 1 and fires into the output register. Throughput:
// one item per cycle unless the result side stalls; the window and running-score
// memories are read when the item is taken and written as it leaves stage 1.
// Reset: clears counters, latch and valid bits (window and running scores read
// as zero until written), threshold back to 90; usable the cycle after reset.
module keyword_score_smoothing_detector #(
	parameter int NUM_CLASSES  = kssd_pkg::NUM_CLASSES_DEF,
	parameter int WINDOW_DEPTH = kssd_pkg::WINDOW_DEPTH_DEF,
	parameter int MISS_FACTOR  = kssd_pkg::MISS_FACTOR_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	kssd_cfg_if.sink        cfg,
	kssd_score_if.sink      score,
	kssd_result_if.source   result
);

	localparam logic [kssd_pkg::CLS_W-1:0]  LAST_CLS   = kssd_pkg::CLS_W'(NUM_CLASSES - 1);
	localparam logic [kssd_pkg::SLOT_W-1:0] LAST_SLOT  = kssd_pkg::SLOT_W'(WINDOW_DEPTH - 1);
	localparam logic [kssd_pkg::SLOT_W-1:0] SLOT_RESET = kssd_pkg::SLOT_W'(1 % WINDOW_DEPTH);

	logic signed [kssd_pkg::RUN_W-1:0]  thr_q;
	logic [kssd_pkg::CLS_W-1:0]         class_pos_q;
	logic [kssd_pkg::SLOT_W-1:0]        slot_q;
	logic                               s1_vld_q;
	kssd_pkg::item_t                    item_s1;
	kssd_pkg::item_t                    item_in;
	kssd_pkg::pipe_ctl_t                ctl;
	logic                               out_vld_q;
	logic signed [kssd_pkg::RUN_W-1:0]  smoothed_q;
	logic                               wake_event_q;
	logic [kssd_pkg::CLS_W-1:0]         wake_class_q;
	logic                               frame_last_q;

	logic signed [kssd_pkg::SUM_W-1:0]  window_sum;
	logic signed [kssd_pkg::RUN_W-1:0]  smoothed;
	kssd_pkg::wake_res_t                wake;

	assign cfg.ready = 1'b1;

	assign ctl.fire   = s1_vld_q && (!out_vld_q || result.ready);
	assign score.ready = !s1_vld_q || ctl.fire;
	assign ctl.load   = score.valid && score.ready;

	assign item_in.cls   = class_pos_q;
	assign item_in.slot  = slot_q;
	assign item_in.score = score.class_score;
	assign item_in.last  = class_pos_q == LAST_CLS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= kssd_pkg::THRESHOLD_RESET;
		end else if (cfg.valid && cfg.ready) begin
			thr_q <= cfg.wake_threshold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_pos_q <= '0;
			slot_q      <= SLOT_RESET;
			s1_vld_q    <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (ctl.load) begin
				if (item_in.last) begin
					class_pos_q <= '0;
					slot_q      <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
				end else begin
					class_pos_q <= class_pos_q + 1'b1;
				end
			end
			if (ctl.load)
				s1_vld_q <= 1'b1;
			else if (ctl.fire)
				s1_vld_q <= 1'b0;
			if (ctl.fire)
				out_vld_q <= 1'b1;
			else if (result.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load)
			item_s1 <= item_in;
		if (ctl.fire) begin
			smoothed_q   <= smoothed;
			wake_event_q <= wake.wake_new;
			wake_class_q <= wake.cls;
			frame_last_q <= item_s1.last;
		end
	end

	kssd_window #(
		.NUM_CLASSES  (NUM_CLASSES),
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.item_in    (item_in),
		.item_s1    (item_s1),
		.window_sum (window_sum)
	);

	kssd_smooth #(
		.NUM_CLASSES  (NUM_CLASSES),
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_smooth (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.item_in    (item_in),
		.item_s1    (item_s1),
		.window_sum (window_sum),
		.smoothed   (smoothed)
	);

	kssd_wake #(
		.NUM_CLASSES (NUM_CLASSES),
		.MISS_FACTOR (MISS_FACTOR)
	) u_wake (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.item_s1   (item_s1),
		.smoothed  (smoothed),
		.threshold (thr_q),
		.wake      (wake)
	);

	assign result.valid          = out_vld_q;
	assign result.smoothed_value = smoothed_q;
	assign result.wake_event     = wake_event_q;
	assign result.wake_class     = wake_class_q;
	assign result.frame_last     = frame_last_q;

	// class zero never wakes
	a_wake_class_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.wake_event |-> result.wake_class != '0)
		else $error("wake event reported for class zero");

	a_class_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load && item_in.last |=> class_pos_q == '0)
		else $error("class position did not wrap after last class");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_q && !ctl.fire |=> s1_vld_q && $stable(item_s1))
		else $error("stage 1 item lost while output stalled");

endmodule
